// ===== rtl/scan_polar_to_cartesian_macros.svh =====
// assertion macros for the scan polar to cartesian block
`ifndef SCAN_POLAR_TO_CARTESIAN_MACROS_SVH
`define SCAN_POLAR_TO_CARTESIAN_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define SPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spc_pkg.sv =====
// shared constants, sine coefficients and types for the polar to cartesian block
package spc_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned RANGE_BITS_DEF = 16;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W     = 17;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned FRAC_W    = 30;
  localparam int unsigned SIN_W     = 31;
  localparam int unsigned NUM_COEF  = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE   = 2'd3;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // odd taylor terms of sin(pi*t/2) in q30, lowest degree first
  localparam logic [SIN_W-1:0] SIN_COEF [NUM_COEF] = '{
    31'd1686629713, 31'd693598668, 31'd85569306,
    31'd5026995,    31'd172272,    31'd3864
  };

  typedef struct packed {
    logic       in_range;
    logic [1:0] quad;
  } pt_ctrl_t;

endpackage

// ===== rtl/scan_polar_to_cartesian.sv =====
// top level of the lidar scan polar to cartesian converter
// usage:
//   input channel carries one range sample (range_mm_i, scan_start_i) per transfer;
//   scan_start_i restarts the angle at start_angle, later samples add angle_step.
//   output channel carries one point (x_mm_o, y_mm_o, point_valid_o) per input sample,
//   in input order; an out-of-limits range gives zeros with point_valid_o low.
//   throughput: one sample per cycle while out_stall_i is low; each of the ten stages
//   (input register, sine square, five horner steps, final sine product, range product,
//   output register) takes a new item every cycle while out_stall_i is low.
//   the config port writes registers on any cycle with cfg_we_i high; write only
//   while no samples are in flight.
//   reset: pipeline empties, next angle and angle registers clear, max_range = 65535.
//   a stalled output holds its point; each stage keeps its item until the next
//   stage frees, so input is refused only once every stage holds an item.
module scan_polar_to_cartesian #(
  parameter int unsigned ANGLE_BITS = spc_pkg::ANGLE_BITS_DEF,
  parameter int unsigned RANGE_BITS = spc_pkg::RANGE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [RANGE_BITS-1:0]         range_mm_i,
  input  logic                          scan_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [spc_pkg::OUT_W-1:0]     x_mm_o,
  output logic [spc_pkg::OUT_W-1:0]     y_mm_o,
  output logic                          point_valid_o
);
  import spc_pkg::*;

  localparam int unsigned NSTG  = 10;
  localparam int unsigned LAST  = NSTG - 1;
  localparam int unsigned CMP_W = (RANGE_BITS > CFG_W) ? RANGE_BITS : CFG_W;

  logic [CFG_W-1:0] start_q, step_q, min_q, max_q;

  logic [ANGLE_BITS-1:0] next_angle_q, ang, start_ang, step_ang;
  logic [FRAC_W-1:0]     frac;
  logic                  in_range;

  logic [LAST:0] vld_q, vld_d, take, up, en;

  logic [RANGE_BITS-1:0] r_q    [0:7];
  pt_ctrl_t              ctrl_q [0:7];
  logic [SIN_W-1:0]      ta_q, tb_q;
  logic [SIN_W-1:0]      s_f, s_c;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      step_q  <= '0;
      min_q   <= '0;
      max_q   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_ANGLE: start_q <= cfg_wdata_i;
        CFG_ANGLE_STEP:  step_q  <= cfg_wdata_i;
        CFG_MIN_RANGE:   min_q   <= cfg_wdata_i;
        CFG_MAX_RANGE:   max_q   <= cfg_wdata_i;
      endcase
    end
  end

  // stage handshake: a stage takes an item when empty or when its item moves on
  always_comb begin
    take[LAST] = !vld_q[LAST] || !out_stall_i;
    for (int i = LAST - 1; i >= 0; i--) begin
      take[i] = !vld_q[i] || take[i+1];
    end
    up = {vld_q[LAST-1:0], in_valid_i};
    en = take & up;
    for (int i = 0; i <= LAST; i++) begin
      vld_d[i] = take[i] ? up[i] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !take[0];
  assign out_valid_o = vld_q[LAST];

  // sample angle
  assign start_ang = ANGLE_BITS'(32'(signed'(start_q)));
  assign step_ang  = ANGLE_BITS'(32'(signed'(step_q)));
  assign ang       = scan_start_i ? start_ang : next_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_angle_q <= '0;
    end else if (en[0]) begin
      next_angle_q <= ang + step_ang;
    end
  end

  assign frac     = FRAC_W'(ang) << (32 - ANGLE_BITS);
  assign in_range = !(CMP_W'(range_mm_i) < CMP_W'(min_q)) &&
                    !(CMP_W'(range_mm_i) > CMP_W'(max_q));

  // input register; range and quadrant travel alongside the sine pipeline
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q[0]             <= range_mm_i;
      ctrl_q[0].in_range <= in_range;
      ctrl_q[0].quad     <= ang[ANGLE_BITS-1 -: 2];
      ta_q               <= {1'b0, frac};
      tb_q               <= (SIN_W'(1) << FRAC_W) - {1'b0, frac};
    end
    for (int i = 1; i <= 7; i++) begin
      if (en[i]) begin
        r_q[i]    <= r_q[i-1];
        ctrl_q[i] <= ctrl_q[i-1];
      end
    end
  end

  spc_sine u_sine_f (
    .clk_i (clk_i),
    .en_i  (en[7:1]),
    .t_i   (ta_q),
    .s_o   (s_f)
  );

  spc_sine u_sine_c (
    .clk_i (clk_i),
    .en_i  (en[7:1]),
    .t_i   (tb_q),
    .s_o   (s_c)
  );

  spc_scale #(
    .RANGE_BITS (RANGE_BITS)
  ) u_scale (
    .clk_i         (clk_i),
    .en_i          (en[9:8]),
    .r_i           (r_q[7]),
    .s_f_i         (s_f),
    .s_c_i         (s_c),
    .ctrl_i        (ctrl_q[7]),
    .x_mm_o        (x_mm_o),
    .y_mm_o        (y_mm_o),
    .point_valid_o (point_valid_o)
  );

endmodule

// ===== rtl/spc_sine.sv =====
// pipelined quarter-wave sine: square, five horner steps and a final product
module spc_sine (
  input  logic                     clk_i,
  input  logic [7:1]               en_i,
  input  logic [spc_pkg::SIN_W-1:0] t_i,
  output logic [spc_pkg::SIN_W-1:0] s_o
);
  import spc_pkg::*;

  logic [SIN_W-1:0]   t_q   [1:6];
  logic [SIN_W-1:0]   t2_q  [1:5];
  logic [SIN_W-1:0]   acc_q [2:6];
  logic [SIN_W-1:0]   s_q;
  logic [2*SIN_W-1:0] sq;
  logic [2*SIN_W-1:0] fin;

  assign sq = (2*SIN_W)'(t_i) * (2*SIN_W)'(t_i);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      t_q[1]  <= t_i;
      t2_q[1] <= sq[FRAC_W +: SIN_W];
    end
  end

  for (genvar k = 2; k <= 6; k++) begin : g_horner
    logic [SIN_W-1:0]   acc_in;
    logic [2*SIN_W-1:0] prod;

    if (k == 2) begin : g_first
      assign acc_in = SIN_COEF[NUM_COEF-1];
    end else begin : g_next
      assign acc_in = acc_q[k-1];
    end

    assign prod = (2*SIN_W)'(t2_q[k-1]) * (2*SIN_W)'(acc_in);

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        t_q[k]   <= t_q[k-1];
        acc_q[k] <= SIN_COEF[6-k] - prod[FRAC_W +: SIN_W];
      end
    end

    if (k < 6) begin : g_t2
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          t2_q[k] <= t2_q[k-1];
        end
      end
    end
  end

  assign fin = (2*SIN_W)'(t_q[6]) * (2*SIN_W)'(acc_q[6]);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s_q <= fin[FRAC_W +: SIN_W];
    end
  end

  assign s_o = s_q;

endmodule

// ===== rtl/spc_scale.sv =====
// quadrant mapping, range scaling with rounding, saturation and sign of the point
module spc_scale #(
  parameter int unsigned RANGE_BITS = spc_pkg::RANGE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic [1:0]                en_i,
  input  logic [RANGE_BITS-1:0]     r_i,
  input  logic [spc_pkg::SIN_W-1:0] s_f_i,
  input  logic [spc_pkg::SIN_W-1:0] s_c_i,
  input  spc_pkg::pt_ctrl_t         ctrl_i,
  output logic [spc_pkg::OUT_W-1:0] x_mm_o,
  output logic [spc_pkg::OUT_W-1:0] y_mm_o,
  output logic                      point_valid_o
);
  import spc_pkg::*;

  localparam int unsigned PW = RANGE_BITS + SIN_W + 1;
  localparam int unsigned MW = PW - FRAC_W;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_W - 1);

  logic [SIN_W-1:0] cv, sv;
  logic             cneg, sneg;
  logic [PW-1:0]    sum_x, sum_y;
  logic [MW-1:0]    mag_x_q, mag_y_q;
  logic             cneg_q, sneg_q, in_range_q;
  logic [MAG_W-1:0] sat_x, sat_y;
  logic [OUT_W-1:0] x_d, y_d;
  logic [OUT_W-1:0] x_q, y_q;
  logic             pv_q;

  always_comb begin
    unique case (ctrl_i.quad)
      2'd0: begin
        sv = s_f_i; sneg = 1'b0; cv = s_c_i; cneg = 1'b0;
      end
      2'd1: begin
        sv = s_c_i; sneg = 1'b0; cv = s_f_i; cneg = 1'b1;
      end
      2'd2: begin
        sv = s_f_i; sneg = 1'b1; cv = s_c_i; cneg = 1'b1;
      end
      2'd3: begin
        sv = s_c_i; sneg = 1'b1; cv = s_f_i; cneg = 1'b0;
      end
    endcase
  end

  assign sum_x = PW'(r_i) * PW'(cv) + HALF;
  assign sum_y = PW'(r_i) * PW'(sv) + HALF;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mag_x_q    <= sum_x[FRAC_W +: MW];
      mag_y_q    <= sum_y[FRAC_W +: MW];
      cneg_q     <= cneg;
      sneg_q     <= sneg;
      in_range_q <= ctrl_i.in_range;
    end
  end

  assign sat_x = (32'(mag_x_q) > 32'(MAG_MAX)) ? MAG_MAX : MAG_W'(mag_x_q);
  assign sat_y = (32'(mag_y_q) > 32'(MAG_MAX)) ? MAG_MAX : MAG_W'(mag_y_q);

  always_comb begin
    x_d = '0;
    y_d = '0;
    if (in_range_q) begin
      x_d = cneg_q ? (OUT_W'(0) - OUT_W'(sat_x)) : OUT_W'(sat_x);
      y_d = sneg_q ? (OUT_W'(0) - OUT_W'(sat_y)) : OUT_W'(sat_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q  <= x_d;
      y_q  <= y_d;
      pv_q <= in_range_q;
    end
  end

  assign x_mm_o        = x_q;
  assign y_mm_o        = y_q;
  assign point_valid_o = pv_q;

endmodule

// ===== rtl/spc_checker.sv =====
// port-level assertion checker for the polar to cartesian block, bound to the top level
`include "scan_polar_to_cartesian_macros.svh"

module spc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [spc_pkg::OUT_W-1:0]     x_mm_o,
  input logic [spc_pkg::OUT_W-1:0]     y_mm_o,
  input logic                          point_valid_o
);
  import spc_pkg::*;

  localparam logic [OUT_W-1:0] MOST_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  // an empty output stage means every stage can take an item
  `SPC_ASSERT_SAME(a_empty_no_stall, !out_valid_o, !in_stall_o, "stall with empty output")

  `SPC_ASSERT_SAME(a_invalid_zero, out_valid_o && !point_valid_o,
    x_mm_o == '0 && y_mm_o == '0, "invalid point with nonzero coordinates")

  // saturation keeps magnitudes at 65535 or below
  `SPC_ASSERT_SAME(a_sat_range, out_valid_o,
    x_mm_o != MOST_NEG && y_mm_o != MOST_NEG, "coordinate beyond saturation limit")

  `SPC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(x_mm_o) && $stable(y_mm_o) && $stable(point_valid_o),
    "stalled point changed")

endmodule

bind scan_polar_to_cartesian spc_checker u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .x_mm_o        (x_mm_o),
  .y_mm_o        (y_mm_o),
  .point_valid_o (point_valid_o)
);
